// File: rtl/core/spq_pkg.sv
package spq_pkg;

    // Default number of cells in the chain.
    localparam int DefaultDepth = 16;

    // Widths fixed by the transfer format.
    localparam int ValueW     = 32;
    localparam int PrioW      = 8;
    localparam int StatusW    = 2;
    localparam int OccupancyW = 5;

    // Input action codes carried on s_tuser.
    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_DEQUEUE = 1'b1
    } action_t;

    // Result status codes carried on m_tuser.
    typedef enum logic [StatusW-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // Operation broadcast to every cell in the same cycle.
    typedef enum logic [1:0] {
        OP_IDLE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } cell_op_t;

    // One stored entry.
    typedef struct packed {
        logic signed [ValueW-1:0] value;
        logic [PrioW-1:0]         prio;
    } entry_t;

    // Command seen by all cells.
    typedef struct packed {
        cell_op_t op;
        entry_t   item;
    } cell_cmd_t;

endpackage

// File: rtl/core/spq_cell.sv
module spq_cell (
    input  logic               aclk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic               occupied,
    input  logic               left_keep,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               keep
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // An occupied cell of equal or higher priority stays ahead of a new entry.
    assign keep  = occupied && (entry_reg.prio >= cmd.item.prio);
    assign entry = entry_reg;

    // On a push the first non-keeping cell takes the new entry and the cells
    // behind it shift toward the tail; on a pop every cell moves toward the head.
    always_comb begin
        entry_next = entry_reg;
        unique case (cmd.op)
            spq_pkg::OP_PUSH: begin
                if (keep) begin
                    entry_next = entry_reg;
                end else if (left_keep) begin
                    entry_next = cmd.item;
                end else begin
                    entry_next = left_entry;
                end
            end
            spq_pkg::OP_POP: begin
                entry_next = right_entry;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// File: rtl/core/sorted_priority_queue_top.sv
// Sorted priority queue built as a chain of cells, head at cell 0.
// Slave channel: s_tuser selects enqueue (0) or dequeue (1); s_tdata carries
// the value and its priority. Each accepted transfer yields exactly one
// result transfer on the master channel: the dequeued value (zero otherwise),
// a status code on m_tuser and the occupancy after the operation.
// Entries leave in descending priority order and in arrival order among
// equal priorities. An enqueue into a full queue is dropped with status full;
// a dequeue of an empty queue reports underflow and changes nothing.
// The result is registered and shown in the cycle after the input transfer.
// Every cell compares and shifts in parallel, so one item is taken each cycle
// while the receiver takes each result; the single result register sets this rate.
// When the receiver stalls, the result register holds its transfer and
// s_tready stays low until it is taken; a taken result frees the slot in the
// same cycle for the next input.
// After reset the queue is empty and no result is pending. The cell contents
// are not cleared; only cells below the entry count are ever read.
module sorted_priority_queue_top #(
    parameter int DEPTH = spq_pkg::DefaultDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item_value [31:0], item_priority [39:32]
    input  logic        s_tuser,   // action [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // head_value [31:0], occupancy [36:32], zero above
    output logic [1:0]  m_tuser    // status [1:0]
);

    localparam int CountW = $clog2(DEPTH + 1);

    spq_pkg::cell_cmd_t cmd;
    spq_pkg::entry_t    cell_entry [DEPTH];
    logic [DEPTH-1:0]   cell_keep;
    logic [DEPTH-1:0]   cell_occ;

    logic [CountW-1:0]  count_reg, count_next;
    logic               m_valid_reg;
    logic signed [spq_pkg::ValueW-1:0] head_reg, head_next;
    spq_pkg::status_t   status_reg, status_next;
    logic [spq_pkg::OccupancyW-1:0] occ_reg, occ_next;
    logic [31:0]        count_ext;

    logic               in_fire;
    logic               is_full;
    logic               is_empty;
    spq_pkg::action_t   action;

    assign action   = spq_pkg::action_t'(s_tuser);
    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign is_full  = (count_reg == CountW'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Command decode for the chain.
    always_comb begin
        cmd.item.value = s_tdata[31:0];
        cmd.item.prio  = s_tdata[39:32];
        cmd.op         = spq_pkg::OP_IDLE;
        if (in_fire) begin
            if (action == spq_pkg::ACT_ENQUEUE) begin
                if (!is_full) begin
                    cmd.op = spq_pkg::OP_PUSH;
                end
            end else if (!is_empty) begin
                cmd.op = spq_pkg::OP_POP;
            end
        end
    end

    // The row of cells; each sees its neighbors, and the end cells see their one neighbor.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign cell_occ[i] = (CountW'(i) < count_reg);
        spq_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .occupied    (cell_occ[i]),
            .left_keep   ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1]),
            .left_entry  (cell_entry[(i == 0) ? 0 : i - 1]),
            .right_entry (cell_entry[(i == DEPTH - 1) ? i : i + 1]),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    // Next count and result fields.
    always_comb begin
        count_next  = count_reg;
        head_next   = '0;
        status_next = spq_pkg::ST_OK;
        if (action == spq_pkg::ACT_ENQUEUE) begin
            if (is_full) begin
                status_next = spq_pkg::ST_FULL;
            end else begin
                count_next = count_reg + CountW'(1);
            end
        end else if (is_empty) begin
            status_next = spq_pkg::ST_UNDERFLOW;
        end else begin
            count_next = count_reg - CountW'(1);
            head_next  = cell_entry[0].value;
        end
        count_ext = 32'(count_next);
        occ_next  = count_ext[spq_pkg::OccupancyW-1:0];
    end

    // Entry count and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            head_reg   <= head_next;
            status_reg <= status_next;
            occ_reg    <= occ_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, occ_reg, head_reg};
    assign m_tuser  = status_reg;

    // Occupied cells must stay in non-increasing priority order.
    logic order_ok;
    always_comb begin
        order_ok = 1'b1;
        for (int k = 0; k < DEPTH - 1; k++) begin
            if (cell_occ[k + 1] && (cell_entry[k].prio < cell_entry[k + 1].prio)) begin
                order_ok = 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountW'(DEPTH))
        else $error("entry count exceeds depth");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        order_ok)
        else $error("cell chain out of priority order");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == spq_pkg::OP_PUSH |=> count_reg == $past(count_reg) + CountW'(1))
        else $error("push did not grow the queue");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && status_next == spq_pkg::ST_FULL |-> is_full && cmd.op == spq_pkg::OP_IDLE)
        else $error("full reported while space remains");

    a_pop_head: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == spq_pkg::OP_POP |=> head_reg == $past(cell_entry[0].value))
        else $error("dequeued value is not the head entry");

endmodule
